>>> src/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_pkg: shared definitions for the glob wildcard matcher
// Item kinds, pattern metacharacters, the byte fold and the cell control bus.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int PATTERN_CHARS_DEF = 32;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_FINISH  = 2'd3
    } mode_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic       rearm;     // reload the active set from the start position
        logic       step;      // advance the active set by one subject byte
        logic       wr_en;     // store char at the current pattern length
        logic       fold;      // case-insensitive literal compare
        logic [7:0] char;      // pattern or subject byte
    } cell_ctl_t;

    // Fold ASCII A-Z to a-z when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> src/gwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of the matcher row
// Holds one pattern byte and the active bit of its position; hands the match
// and star-closure bits on to the next cell.
// ----------------------------------------------------------------------------
module gwm_cell #(
    parameter int N   = gwm_pkg::PATTERN_CHARS_DEF,
    parameter int IDX = 0,
    parameter int LW  = $clog2(N + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gwm_pkg::cell_ctl_t ctl,
    input  logic [LW-1:0]     len,        // current pattern length
    input  logic [LW-1:0]     len_next,   // pattern length after this transfer
    input  logic              fwd_in,     // previous position consumed the byte
    input  logic              carry_in,   // star closure from the previous position
    output logic              fwd_out,
    output logic              carry_out,
    output logic              act
);

    localparam logic IS_FIRST = (IDX == 0);

    logic [7:0] pat_reg;
    logic       act_reg;
    logic       act_next;

    logic       wr_here;
    logic [7:0] pat_eff;
    logic       valid_eff;
    logic       is_star;
    logic       hit;
    logic       raw;
    logic       closed;

    // The byte being appended is seen already, so the rearm closure covers it
    assign wr_here   = ctl.wr_en && (len == LW'(IDX));
    assign pat_eff   = wr_here ? ctl.char : pat_reg;
    assign valid_eff = (len_next > LW'(IDX));
    assign is_star   = valid_eff && (pat_eff == gwm_pkg::STAR_BYTE);
    assign hit       = valid_eff && !is_star &&
                       ((pat_eff == gwm_pkg::QMARK_BYTE) ||
                        (gwm_pkg::fold_byte(pat_eff, ctl.fold) ==
                         gwm_pkg::fold_byte(ctl.char, ctl.fold)));

    assign raw       = ctl.rearm ? IS_FIRST : ((act_reg && is_star) || fwd_in);
    assign closed    = raw || carry_in;
    assign fwd_out   = act_reg && hit;
    assign carry_out = closed && is_star;
    assign act_next  = (ctl.rearm || ctl.step) ? closed : act_reg;
    assign act       = act_reg;

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            pat_reg <= ctl.char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= IS_FIRST;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

>>> src/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher: whole-string glob matcher, '*' and '?'
// Loads a pattern byte by byte, streams a subject string and reports on
// finish whether the whole subject matched the whole pattern.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no result waits untaken, for
// every kind of item: pattern clear, pattern append, subject byte and finish. The
// finish result appears in the cycle after its transfer and sits in an
// output register; input transfers stall only while a result waits there
// untaken, and resume in the cycle it is taken.
// The pattern lives in a row of PATTERN_CHARS+1 cells, one per position, each
// holding its byte and its active bit; the clock period is set by the star
// closure rippling along that row. No start-up pass is needed after reset.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
    parameter int PATTERN_CHARS = gwm_pkg::PATTERN_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,        // [0] case_insensitive
    // items in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] char_value
    input  logic [1:0] s_axis_tuser,    // [1:0] mode
    // results out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int N  = PATTERN_CHARS;
    localparam int LW = $clog2(N + 1);

    logic          fold_reg;
    logic [LW-1:0] len_reg,  len_next;
    logic          ovf_reg,  ovf_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_match_reg;
    logic          out_ovf_reg;

    logic               accept;
    logic               emit;
    logic               nz;
    gwm_pkg::mode_t     mode;
    gwm_pkg::cell_ctl_t ctl;

    logic [N:0] fwd;
    logic [N:0] carry;
    logic [N:0] act_vec;
    logic [N:0] fwd_out;
    logic [N:0] carry_out;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = gwm_pkg::mode_t'(s_axis_tuser);
    assign nz            = (s_axis_tdata != gwm_pkg::NUL_BYTE);

    always_comb
    begin
        ctl.rearm = 1'b0;
        ctl.step  = 1'b0;
        ctl.wr_en = 1'b0;
        ctl.fold  = fold_reg;
        ctl.char  = s_axis_tdata;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        emit      = 1'b0;
        if (accept)
        begin
            case (mode)
                gwm_pkg::MODE_CLEAR:
                begin
                    ctl.rearm = 1'b1;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                end
                gwm_pkg::MODE_APPEND:
                begin
                    // drop terminators; drop and flag bytes beyond capacity
                    if (nz)
                    begin
                        ctl.rearm = 1'b1;
                        if (len_reg < LW'(N))
                        begin
                            ctl.wr_en = 1'b1;
                            len_next  = len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                gwm_pkg::MODE_SUBJECT:
                begin
                    ctl.step = nz;
                end
                gwm_pkg::MODE_FINISH:
                begin
                    ctl.rearm = 1'b1;
                    emit      = 1'b1;
                end
                default:
                begin
                    ctl.rearm = 1'b0;
                end
            endcase
        end
    end

    assign fwd[0]   = 1'b0;
    assign carry[0] = 1'b0;

    for (genvar i = 0; i <= N; i++)
    begin : g_cell
        gwm_cell #(
            .N   (N),
            .IDX (i),
            .LW  (LW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .len       (len_reg),
            .len_next  (len_next),
            .fwd_in    (fwd[i]),
            .carry_in  (carry[i]),
            .fwd_out   (fwd_out[i]),
            .carry_out (carry_out[i]),
            .act       (act_vec[i])
        );
        if (i < N)
        begin : g_link
            assign fwd[i+1]   = fwd_out[i];
            assign carry[i+1] = carry_out[i];
        end
    end

    // hold the result until taken
    assign out_valid_next = emit || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg      <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fold_reg <= cfg_data;
            end
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_match_reg <= act_vec[len_reg];
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_ovf_reg, out_match_reg};

    // fwd_out and carry_out of the last cell end the row
    logic unused_tail;
    assign unused_tail = fwd_out[N] ^ carry_out[N];

endmodule

>>> src/gwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_checker: port-level checks for the glob wildcard matcher
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module gwm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // a finish transfer always produces a result next cycle
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tuser == gwm_pkg::MODE_FINISH) |=> m_axis_tvalid)
        else $error("finish transfer produced no result");

    // other transfers never invent a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tuser != gwm_pkg::MODE_FINISH && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("result without a finish transfer");

    // empty pattern matches the empty subject, with no overflow
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tuser == gwm_pkg::MODE_CLEAR) ##1
        (acc && s_axis_tuser == gwm_pkg::MODE_FINISH)
        |=> (m_axis_tvalid && m_axis_tdata[1:0] == 2'b01))
        else $error("empty pattern did not match empty subject");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    logic unused_data;
    assign unused_data = ^s_axis_tdata;

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
